[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/stst_pkg.sv]
// ---------------------------------------------------------------------------
// stst_pkg
// Types and constants for the structure tensor block.
// ---------------------------------------------------------------------------
package stst_pkg;

	localparam int MAX_LINE_DEF  = 1024;
	localparam int CHAN_BITS_DEF = 16;
	localparam int MAX_HEIGHT    = 1024;

	// derivative kernel taps, Q0.16
	localparam logic [15:0] COEF_EDGE = 16'd5997;
	localparam logic [15:0] COEF_MID  = 16'd20775;

	// register indexes
	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_THRESH  = 2'd2;
	localparam logic [1:0] REG_HELD_EN = 2'd3;

	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [10:0] RST_HEIGHT = 11'd480;

	typedef logic [47:0] pixel_t;
	// [0] top, [1] middle, [2] bottom
	typedef pixel_t [2:0] column_t;

	typedef struct packed {
		logic [10:0] width;
		logic [10:0] height;
		logic [33:0] thresh;
		logic        held_en;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        e;
		logic [31:0]        g;
		logic signed [32:0] f;
		logic [33:0]        mag;
	} tensor_t;

	typedef struct packed {
		column_t l;
		column_t m;
		column_t r;
		tensor_t held;
		logic    last;
	} job_t;

	typedef struct packed {
		tensor_t t;
		logic    last;
	} result_t;

endpackage

[rtl/core/stst_ram.sv]
// ---------------------------------------------------------------------------
// stst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module stst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/stst_fifo.sv]
// ---------------------------------------------------------------------------
// stst_fifo
// Small register-based queue used between the block's parts and at its output.
// ---------------------------------------------------------------------------
module stst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/stst_front.sv]
// ---------------------------------------------------------------------------
// stst_front
// Accepts pixels and flush requests, keeps the line stores, the window and
// the held-tensor delay line, and issues one tensor job per result.
// ---------------------------------------------------------------------------
module stst_front #(
	parameter int MAX_LINE = stst_pkg::MAX_LINE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stst_pkg::cfg_t        cfg,
	input  logic                  push,
	output logic                  full,
	input  logic                  func,
	input  logic [15:0]           chan_a,
	input  logic [15:0]           chan_b,
	input  logic [15:0]           chan_c,
	input  stst_pkg::tensor_t     held_in,
	output logic                  job_valid,
	output stst_pkg::job_t        job,
	input  logic                  job_full
);

	import stst_pkg::*;

	localparam int CW  = $clog2(MAX_LINE + 1);
	localparam int PW  = $clog2(MAX_LINE + 2);
	localparam int RAW = $clog2(MAX_LINE);
	localparam int HAW = $clog2(MAX_LINE + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic            state_q;
	logic            flush_q;
	logic [CW-1:0]   col_q, cur_q;
	logic [10:0]     row_q;
	logic [PW-1:0]   pend_q;
	logic [HAW-1:0]  hptr_q;
	pixel_t          px_q;
	tensor_t         hin_q;
	column_t         win_q, prev_q;

	logic [31:0]     w32, h32, wp1_32, hnext32;
	logic [CW-1:0]   w;
	logic [PW-1:0]   wp1;
	logic [10:0]     h;
	logic            accept;
	logic [CW-1:0]   c0;
	logic [10:0]     r0;
	logic [PW-1:0]   pcap, kfull;
	logic [RAW-1:0]  row_raddr;
	logic [95:0]     row_rdata;
	logic [$bits(tensor_t)-1:0] held_rdata;
	pixel_t          upper, lower;
	column_t         col_v;
	logic            shift_en;
	logic            row_we, held_we;
	logic [CW:0]     nc;
	logic [10:0]     rn;
	logic [CW-1:0]   one_c;

	assign one_c = {{(CW-1){1'b0}}, 1'b1};

	// effective frame size
	always_comb begin
		w32 = 32'(cfg.width);
		if (w32 < 32'd2) begin
			w32 = 32'd2;
		end else if (w32 > 32'(MAX_LINE)) begin
			w32 = 32'(MAX_LINE);
		end
		h32 = 32'(cfg.height);
		if (h32 < 32'd2) begin
			h32 = 32'd2;
		end else if (h32 > 32'(MAX_HEIGHT)) begin
			h32 = 32'(MAX_HEIGHT);
		end
	end

	assign wp1_32 = w32 + 32'd1;
	assign w      = w32[CW-1:0];
	assign wp1    = wp1_32[PW-1:0];
	assign h      = h32[10:0];

	assign full   = (state_q != S_IDLE) || job_full;
	assign accept = push && !full;

	// position of an incoming pixel after wrap
	always_comb begin
		c0 = col_q;
		r0 = row_q;
		if (c0 >= w) begin
			c0 = '0;
			r0 = r0 + 11'd1;
		end
		if (r0 >= h) begin
			r0 = '0;
		end
	end

	// drain position for a flush
	assign pcap  = (pend_q > wp1) ? wp1 : pend_q;
	assign kfull = wp1 - pcap;

	always_comb begin
		if (!func) begin
			row_raddr = c0[RAW-1:0];
		end else if (kfull[CW-1:0] < w) begin
			row_raddr = kfull[RAW-1:0];
		end else begin
			row_raddr = '0;
		end
	end

	// line stores: {upper, lower} per column
	stst_ram #(
		.WIDTH (96),
		.DEPTH (MAX_LINE)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (cur_q[RAW-1:0]),
		.wdata ({lower, px_q}),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	// held tensor delay line
	stst_ram #(
		.WIDTH ($bits(tensor_t)),
		.DEPTH (MAX_LINE + 1)
	) u_held_ram (
		.clk   (clk),
		.we    (held_we),
		.waddr (hptr_q),
		.wdata (hin_q),
		.raddr (hptr_q),
		.rdata (held_rdata)
	);

	assign upper = row_rdata[95:48];
	assign lower = row_rdata[47:0];
	assign row_we  = (state_q == S_EXEC) && !flush_q;
	assign held_we = row_we;

	// window column and job for the item in execution
	always_comb begin
		job.held = held_rdata;
		job.last = 1'b0;
		job.m    = win_q;
		job.l    = prev_q;
		job.r    = prev_q;
		job_valid = 1'b0;
		shift_en  = 1'b0;
		if (!flush_q) begin
			col_v[0] = (row_q <= 11'd1) ? px_q : upper;
			col_v[1] = lower;
			col_v[2] = px_q;
		end else begin
			col_v[0] = upper;
			col_v[1] = lower;
			col_v[2] = upper;
		end
		if (state_q == S_EXEC) begin
			if (!flush_q) begin
				shift_en = 1'b1;
				if (cur_q == '0) begin
					job_valid = (row_q >= 11'd2);
				end else begin
					job_valid = (row_q >= 11'd1);
					job.l     = (cur_q == one_c) ? col_v : prev_q;
					job.r     = col_v;
				end
			end else begin
				job_valid = 1'b1;
				shift_en  = (cur_q < w);
				if (cur_q == w) begin
					job.last = 1'b1;
				end else if (cur_q != '0) begin
					job.l = (cur_q == one_c) ? col_v : prev_q;
					job.r = col_v;
				end
			end
		end
	end

	assign nc      = {1'b0, cur_q} + 1'b1;
	assign rn      = row_q + 11'd1;
	assign hnext32 = 32'(hptr_q) + 32'd1;

	// item payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q  <= {chan_c, chan_b, chan_a};
			hin_q <= held_in;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flush_q <= 1'b0;
			col_q   <= '0;
			cur_q   <= '0;
			row_q   <= '0;
			pend_q  <= '0;
			hptr_q  <= '0;
			win_q   <= '0;
			prev_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!func) begin
							state_q <= S_EXEC;
							flush_q <= 1'b0;
							cur_q   <= c0;
							col_q   <= c0;
							row_q   <= r0;
							pend_q  <= '0;
						end else if (pend_q != '0) begin
							state_q <= S_EXEC;
							flush_q <= 1'b1;
							pend_q  <= pcap;
							cur_q   <= kfull[CW-1:0];
						end
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					hptr_q  <= (hnext32 >= wp1_32) ? '0 : hnext32[HAW-1:0];
					if (shift_en) begin
						prev_q <= win_q;
						win_q  <= col_v;
					end
					if (!flush_q) begin
						if (nc >= {1'b0, w}) begin
							col_q <= '0;
							if (rn >= h) begin
								row_q  <= '0;
								pend_q <= wp1;
							end else begin
								row_q <= rn;
							end
						end else begin
							col_q <= nc[CW-1:0];
						end
					end else begin
						pend_q <= pend_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/stst_back.sv]
// ---------------------------------------------------------------------------
// stst_back
// Works one job at a time through a shared multiplier: gradients per
// channel, tensor sums, magnitude, threshold and fallback selection.
// ---------------------------------------------------------------------------
module stst_back #(
	parameter int CHAN_BITS = stst_pkg::CHAN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stst_pkg::cfg_t    cfg,
	input  logic              job_avail,
	input  stst_pkg::job_t    job,
	output logic              job_pop,
	output logic              res_valid,
	output stst_pkg::result_t res,
	input  logic              res_full
);

	import stst_pkg::*;

	// step codes; steps below ST_FIN0 run per channel
	localparam logic [4:0] ST_FIN0 = 5'd12;
	localparam logic [4:0] ST_FIN1 = 5'd13;
	localparam logic [4:0] ST_MEE  = 5'd14;
	localparam logic [4:0] ST_MGG  = 5'd15;
	localparam logic [4:0] ST_MFF  = 5'd16;
	localparam logic [4:0] ST_WAIT = 5'd17;
	localparam logic [4:0] ST_OUT  = 5'd18;

	localparam logic [1:0] SUB_GRAD = 2'd0;
	localparam logic [1:0] SUB_XX   = 2'd1;
	localparam logic [1:0] SUB_YY   = 2'd2;
	localparam logic [1:0] SUB_XY   = 2'd3;

	localparam logic [2:0] TAG_NONE = 3'd0;
	localparam logic [2:0] TAG_E    = 3'd1;
	localparam logic [2:0] TAG_G    = 3'd2;
	localparam logic [2:0] TAG_F    = 3'd3;
	localparam logic [2:0] TAG_M    = 3'd4;
	localparam logic [2:0] TAG_M2   = 3'd5;

	localparam logic signed [33:0] K_EDGE = 34'(COEF_EDGE);
	localparam logic signed [33:0] K_MID  = 34'(COEF_MID);

	logic [4:0]          st_q;
	logic [2:0]          tag_q, op_tag;
	logic signed [21:0]  gx_q, gy_q;
	logic signed [67:0]  prod_q;
	logic signed [47:0]  se_q, sg_q, sf_q;
	logic [35:0]         mag_q;
	logic [31:0]         e_q, g_q;
	logic signed [32:0]  f_q;
	logic [32:0]         fa_q;

	logic                advance;
	logic [1:0]          ch, sub;
	logic                is_chan;
	logic signed [33:0]  tl, ml, bl, tm, bm, tr, mr, br;
	logic signed [33:0]  gx_full, gy_full, gx_sh, gy_sh;
	logic signed [33:0]  op_a, op_b;
	logic signed [47:0]  f_full;

	function automatic logic signed [33:0] chan_of(pixel_t p, logic [1:0] k);
		logic [15:0] v;
		case (k)
			2'd0:    v = p[15:0];
			2'd1:    v = p[31:16];
			default: v = p[47:32];
		endcase
		return $signed({{(34 - CHAN_BITS){1'b0}}, v[15 -: CHAN_BITS]});
	endfunction

	assign ch      = st_q[3:2];
	assign sub     = st_q[1:0];
	assign is_chan = (st_q < ST_FIN0);
	assign advance = job_avail && ((st_q != ST_OUT) || !res_full);

	// window taps for the current channel
	assign tl = chan_of(job.l[0], ch);
	assign ml = chan_of(job.l[1], ch);
	assign bl = chan_of(job.l[2], ch);
	assign tm = chan_of(job.m[0], ch);
	assign bm = chan_of(job.m[2], ch);
	assign tr = chan_of(job.r[0], ch);
	assign mr = chan_of(job.r[1], ch);
	assign br = chan_of(job.r[2], ch);

	// gradients, floored to Q0.20
	assign gx_full = K_EDGE * ((tr - tl) + (br - bl)) + K_MID * (mr - ml);
	assign gy_full = K_EDGE * ((bl - tl) + (br - tr)) + K_MID * (bm - tm);
	assign gx_sh   = gx_full >>> (CHAN_BITS - 4);
	assign gy_sh   = gy_full >>> (CHAN_BITS - 4);

	// shared multiplier operand selection
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_tag = TAG_NONE;
		if (is_chan) begin
			unique case (sub)
				SUB_GRAD: op_tag = TAG_NONE;
				SUB_XX: begin
					op_a   = $signed({{12{gx_q[21]}}, gx_q});
					op_b   = op_a;
					op_tag = TAG_E;
				end
				SUB_YY: begin
					op_a   = $signed({{12{gy_q[21]}}, gy_q});
					op_b   = op_a;
					op_tag = TAG_G;
				end
				SUB_XY: begin
					op_a   = $signed({{12{gx_q[21]}}, gx_q});
					op_b   = $signed({{12{gy_q[21]}}, gy_q});
					op_tag = TAG_F;
				end
				default: op_tag = TAG_NONE;
			endcase
		end else if (st_q == ST_MEE) begin
			op_a   = $signed({2'b00, e_q});
			op_b   = op_a;
			op_tag = TAG_M;
		end else if (st_q == ST_MGG) begin
			op_a   = $signed({2'b00, g_q});
			op_b   = op_a;
			op_tag = TAG_M;
		end else if (st_q == ST_MFF) begin
			op_a   = $signed({1'b0, fa_q});
			op_b   = op_a;
			op_tag = TAG_M2;
		end
	end

	assign f_full = sf_q >>> 8;

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			tag_q <= TAG_NONE;
		end else begin
			tag_q <= advance ? op_tag : TAG_NONE;
			if (advance) begin
				st_q <= (st_q == ST_OUT) ? '0 : st_q + 5'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (advance && is_chan && (sub == SUB_GRAD)) begin
			gx_q <= gx_sh[21:0];
			gy_q <= gy_sh[21:0];
		end
		if (advance && (st_q == '0)) begin
			se_q  <= '0;
			sg_q  <= '0;
			sf_q  <= '0;
			mag_q <= '0;
		end else begin
			case (tag_q)
				TAG_E:   se_q  <= se_q + prod_q[47:0];
				TAG_G:   sg_q  <= sg_q + prod_q[47:0];
				TAG_F:   sf_q  <= sf_q + prod_q[47:0];
				TAG_M:   mag_q <= mag_q + prod_q[67:32];
				TAG_M2:  mag_q <= mag_q + {prod_q[66:32], 1'b0};
				default: ;
			endcase
		end
		if (st_q == ST_FIN1) begin
			e_q  <= se_q[39:8];
			g_q  <= sg_q[39:8];
			f_q  <= f_full[32:0];
			fa_q <= f_full[47] ? 33'(-f_full) : f_full[32:0];
		end
	end

	// threshold and fallback
	always_comb begin
		res.last  = job.last;
		res.t.e   = e_q;
		res.t.g   = g_q;
		res.t.f   = f_q;
		res.t.mag = mag_q[33:0];
		if (mag_q < 36'(cfg.thresh)) begin
			if (cfg.held_en) begin
				res.t = job.held;
			end else begin
				res.t.mag = '0;
			end
		end
	end

	assign res_valid = job_avail && (st_q == ST_OUT) && !res_full;
	assign job_pop   = res_valid;

endmodule

[rtl/core/structure_tensor_sobel_threshold_top.sv]
// Flow: an accepted item passes through the front's execute state into the job queue;
//   at the head of that queue the back steps through it, and its result waits in the
//   result queue until popped.
// Pacing: the front takes no new item while it executes one or the job queue is full;
//   the back works one job at a time on its shared multiplier; a full result queue stalls it.
// Reset: arst_n clears control state, window and counters and loads register defaults;
//   line stores and the held delay line are not cleared.
// ---------------------------------------------------------------------------
// structure_tensor_sobel_threshold_top
// Colour structure tensor over a 3x3 derivative window with magnitude
// threshold and held-tensor fallback.
// ---------------------------------------------------------------------------
module structure_tensor_sobel_threshold_top #(
	parameter int MAX_LINE  = stst_pkg::MAX_LINE_DEF,
	parameter int CHAN_BITS = stst_pkg::CHAN_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [33:0]        wr_data,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic [15:0]        chan_a,
	input  logic [15:0]        chan_b,
	input  logic [15:0]        chan_c,
	input  logic [31:0]        held_e,
	input  logic [31:0]        held_g,
	input  logic signed [32:0] held_f,
	input  logic [33:0]        held_mag,
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        tensor_e,
	output logic [31:0]        tensor_g,
	output logic signed [32:0] tensor_f,
	output logic [33:0]        tensor_mag,
	output logic               frame_last
);

	import stst_pkg::*;

	cfg_t    cfg_q;
	tensor_t held_in;
	logic    job_valid, jq_full, jq_empty, job_pop;
	job_t    job_w, job_head;
	logic    res_valid, rq_full;
	result_t res_w, res_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width   <= RST_WIDTH;
			cfg_q.height  <= RST_HEIGHT;
			cfg_q.thresh  <= '0;
			cfg_q.held_en <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH:   cfg_q.width   <= wr_data[10:0];
				REG_HEIGHT:  cfg_q.height  <= wr_data[10:0];
				REG_THRESH:  cfg_q.thresh  <= wr_data;
				REG_HELD_EN: cfg_q.held_en <= wr_data[0];
				default:     cfg_q.held_en <= cfg_q.held_en;
			endcase
		end
	end

	assign held_in.e   = held_e;
	assign held_in.g   = held_g;
	assign held_in.f   = held_f;
	assign held_in.mag = held_mag;

	stst_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.func      (func),
		.chan_a    (chan_a),
		.chan_b    (chan_b),
		.chan_c    (chan_c),
		.held_in   (held_in),
		.job_valid (job_valid),
		.job       (job_w),
		.job_full  (jq_full)
	);

	// job queue between front and back
	stst_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (2)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_valid),
		.wdata  (job_w),
		.rd     (job_pop),
		.rdata  (job_head),
		.empty  (jq_empty),
		.full   (jq_full)
	);

	stst_back #(
		.CHAN_BITS (CHAN_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_avail (!jq_empty),
		.job       (job_head),
		.job_pop   (job_pop),
		.res_valid (res_valid),
		.res       (res_w),
		.res_full  (rq_full)
	);

	// result queue
	stst_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_valid),
		.wdata  (res_w),
		.rd     (pop),
		.rdata  (res_head),
		.empty  (empty),
		.full   (rq_full)
	);

	assign tensor_e   = res_head.t.e;
	assign tensor_g   = res_head.t.g;
	assign tensor_f   = res_head.t.f;
	assign tensor_mag = res_head.t.mag;
	assign frame_last = res_head.last;

endmodule

[rtl/core/stst_checker.sv]
// ---------------------------------------------------------------------------
// stst_checker
// Port-level checks on the structure tensor block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stst_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               func,
	input logic               empty,
	input logic               pop,
	input logic [31:0]        tensor_e,
	input logic [31:0]        tensor_g,
	input logic signed [32:0] tensor_f,
	input logic [33:0]        tensor_mag,
	input logic               frame_last
);

	logic [131:0] res_bits;

	assign res_bits = {tensor_e, tensor_g, tensor_f, tensor_mag, frame_last};

	// an accepted pixel request keeps the front busy while it executes
	`ASSERT_NEXT(a_pixel_busy, clk, arst_n, push && !full && !func, full)

	// the input side only closes after a request was made
	`ASSERT_IMPLY(a_full_cause, clk, arst_n, $rose(full), $past(push))

	// a waiting result holds until taken
	`ASSERT_NEXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(res_bits))

endmodule

bind structure_tensor_sobel_threshold_top stst_checker u_stst_checker (.*);

[verif/structure_tensor_sobel_threshold_top_tb.sv]
// ---------------------------------------------------------------------------
// structure_tensor_sobel_threshold_top_tb
// Streams frames of colour pixels and flush ticks through the tensor block,
// predicts results from its own copy of line stores, window and held delay
// line or takes them from directed rows; compares in order, field by field.
// ---------------------------------------------------------------------------
module structure_tensor_sobel_threshold_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stst_pkg::*;

	localparam int LINE_MAX = 1024;
	localparam int TARGET_ITEMS = 1300;
	localparam bit FN_PIXEL = 1'b0;
	localparam bit FN_FLUSH = 1'b1;
	localparam logic [33:0] THRESH_TOP = 34'd9663676416;

	typedef struct {
		bit        func;
		bit [15:0] a, b, c;
		bit [31:0] he, hg;
		bit [32:0] hf;
		bit [33:0] hm;
	} pix_req_t;

	// directed row: request plus, where obvious, the tensor it must produce
	typedef struct {
		pix_req_t rq;
		bit       known;
		result_t  want;
	} dir_row_t;

	logic clk, arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [33:0] wr_data;
	logic push, full, empty, pop;
	logic func;
	logic [15:0] chan_a, chan_b, chan_c;
	logic [31:0] held_e, held_g;
	logic signed [32:0] held_f;
	logic [33:0] held_mag;
	logic [31:0] tensor_e, tensor_g;
	logic signed [32:0] tensor_f;
	logic [33:0] tensor_mag;
	logic frame_last;

	structure_tensor_sobel_threshold_top u_top (.*);

	// predictor state
	logic [10:0] sh_width, sh_height;
	logic [33:0] sh_thresh;
	logic        sh_held_en;
	pixel_t      line_up [LINE_MAX];
	pixel_t      line_lo [LINE_MAX];
	column_t     win_cur, win_prev;
	tensor_t     held_line [LINE_MAX + 1];
	int          col_cnt, row_cnt, drain_cnt, held_ptr;

	result_t tensor_queue[$];
	int      err_cnt;
	int      sent;
	bit      calm;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int eff_w();
		int w;
		w = sh_width;
		if (w < 2) w = 2;
		if (w > LINE_MAX) w = LINE_MAX;
		return w;
	endfunction

	function automatic int eff_h();
		int h;
		h = sh_height;
		if (h < 2) h = 2;
		if (h > 1024) h = 1024;
		return h;
	endfunction

	// gradients, tensor sums, magnitude and threshold selection
	function automatic result_t tensor_of(column_t l, column_t m, column_t r, tensor_t hv,
			logic lst);
		longint ce, cm, se, sg, sf, gx, gy, f;
		longint tl, ml, bl, tm, bm, tr, mr, br;
		longint unsigned e, g, fa, mg;
		result_t o;
		ce = COEF_EDGE;
		cm = COEF_MID;
		se = 0; sg = 0; sf = 0;
		for (int k = 0; k < 3; k++) begin
			tl = l[0][16*k +: 16]; ml = l[1][16*k +: 16]; bl = l[2][16*k +: 16];
			tm = m[0][16*k +: 16]; bm = m[2][16*k +: 16];
			tr = r[0][16*k +: 16]; mr = r[1][16*k +: 16]; br = r[2][16*k +: 16];
			gx = ce * (tr - tl) + cm * (mr - ml) + ce * (br - bl);
			gy = ce * (bl - tl) + cm * (bm - tm) + ce * (br - tr);
			gx = gx >>> (CHAN_BITS_DEF - 4);
			gy = gy >>> (CHAN_BITS_DEF - 4);
			se += gx * gx;
			sg += gy * gy;
			sf += gx * gy;
		end
		e = se >> 8;
		g = sg >> 8;
		f = sf >>> 8;
		fa = (f < 0) ? -f : f;
		mg = ((e * e) >> 32) + ((g * g) >> 32) + 2 * ((fa * fa) >> 32);
		o.t.e = e[31:0];
		o.t.g = g[31:0];
		o.t.f = f[32:0];
		o.t.mag = mg[33:0];
		if (mg < {30'd0, sh_thresh}) begin
			if (sh_held_en) o.t = hv;
			else o.t.mag = '0;
		end
		o.last = lst;
		return o;
	endfunction

	function automatic tensor_t held_at();
		return held_line[(held_ptr > LINE_MAX) ? 0 : held_ptr];
	endfunction

	function automatic void advance_held(int w);
		held_ptr = (held_ptr + 1 >= w + 1 || held_ptr + 1 > LINE_MAX) ? 0 : held_ptr + 1;
	endfunction

	function automatic void shift_in(column_t cl);
		win_prev = win_cur;
		win_cur = cl;
	endfunction

	// one accepted request: update state, return whether a tensor comes out
	function automatic bit predict(pix_req_t rq, output result_t res);
		int w, h, c, rr, k;
		pixel_t px;
		column_t cl;
		tensor_t hv;
		bit got;
		w = eff_w();
		h = eff_h();
		got = 0;
		res = '0;
		if (rq.func == FN_PIXEL) begin
			drain_cnt = 0;
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt++;
			end
			if (row_cnt >= h) row_cnt = 0;
			c = col_cnt;
			rr = row_cnt;
			px = {rq.c, rq.b, rq.a};
			cl[0] = (rr <= 1) ? px : line_up[c];
			cl[1] = line_lo[c];
			cl[2] = px;
			hv = held_at();
			if (c == 0) begin
				if (rr >= 2) begin
					res = tensor_of(win_prev, win_cur, win_prev, hv, 1'b0);
					got = 1;
				end
			end else if (rr >= 1) begin
				res = tensor_of((c == 1) ? cl : win_prev, win_cur, cl, hv, 1'b0);
				got = 1;
			end
			shift_in(cl);
			line_up[c] = line_lo[c];
			line_lo[c] = px;
			held_line[(held_ptr > LINE_MAX) ? 0 : held_ptr] = '{rq.he, rq.hg, rq.hf, rq.hm};
			advance_held(w);
			col_cnt++;
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt++;
				if (row_cnt >= h) begin
					row_cnt = 0;
					drain_cnt = w + 1;
				end
			end
			return got;
		end
		if (drain_cnt == 0) return 0;
		if (drain_cnt > w + 1) drain_cnt = w + 1;
		k = w + 1 - drain_cnt;
		hv = held_at();
		advance_held(w);
		cl = '0;
		if (k < w) begin
			cl[0] = line_up[k];
			cl[1] = line_lo[k];
			cl[2] = line_up[k];
		end
		if (k == 0 || k == w)
			res = tensor_of(win_prev, win_cur, win_prev, hv, k == w);
		else
			res = tensor_of((k == 1) ? cl : win_prev, win_cur, cl, hv, 1'b0);
		if (k < w) shift_in(cl);
		drain_cnt--;
		return 1;
	endfunction

	// drive one request and wait for it to be taken
	task automatic send(pix_req_t rq, bit known = 0, result_t want = '0);
		result_t res;
		if (!calm && $urandom_range(99) < 12) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		func <= rq.func;
		chan_a <= rq.a;
		chan_b <= rq.b;
		chan_c <= rq.c;
		held_e <= rq.he;
		held_g <= rq.hg;
		held_f <= rq.hf;
		held_mag <= rq.hm;
		do @(posedge clk); while (full);
		sent++;
		calm = (sent >= 300 && sent < 600);
		if (predict(rq, res)) tensor_queue.push_back(known ? want : res);
	endtask

	// wait for all results, let the back end settle, then write registers
	task automatic set_config(logic [10:0] w, logic [10:0] h, logic [33:0] th, logic he);
		push <= 1'b0;
		@(posedge clk);
		while (tensor_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		wr_en <= 1'b1; wr_index <= REG_WIDTH; wr_data <= 34'(w);
		@(posedge clk);
		wr_index <= REG_HEIGHT; wr_data <= 34'(h);
		@(posedge clk);
		wr_index <= REG_THRESH; wr_data <= th;
		@(posedge clk);
		wr_index <= REG_HELD_EN; wr_data <= 34'(he);
		@(posedge clk);
		wr_en <= 1'b0;
		sh_width = w;
		sh_height = h;
		sh_thresh = th;
		sh_held_en = he;
	endtask

	function automatic pix_req_t rand_pixel(bit smooth, pixel_t base);
		pix_req_t rq;
		rq.func = FN_PIXEL;
		if (smooth) begin
			rq.a = base[15:0] + 16'($urandom_range(0, 255));
			rq.b = base[31:16] + 16'($urandom_range(0, 255));
			rq.c = base[47:32] + 16'($urandom_range(0, 255));
		end else begin
			rq.a = 16'($urandom);
			rq.b = 16'($urandom);
			rq.c = 16'($urandom);
		end
		rq.he = $urandom;
		rq.hg = $urandom;
		rq.hf = {1'($urandom), 32'($urandom)};
		rq.hm = {2'($urandom), 32'($urandom)};
		if (rq.hm > THRESH_TOP) rq.hm = THRESH_TOP;
		return rq;
	endfunction

	function automatic pix_req_t flush_req();
		pix_req_t rq;
		rq = rand_pixel(0, '0);
		rq.func = FN_FLUSH;
		return rq;
	endfunction

	// one frame, optionally with stray flushes; drain full or cut short
	task automatic run_frame(bit full_drain);
		int w, h, nd;
		bit smooth;
		pixel_t base;
		w = eff_w();
		h = eff_h();
		smooth = ($urandom_range(3) == 0);
		base = {16'($urandom), 16'($urandom), 16'($urandom)};
		for (int i = 0; i < w * h; i++) begin
			if ($urandom_range(19) == 0) send(flush_req());
			send(rand_pixel(smooth, base));
		end
		nd = full_drain ? w + 1 + $urandom_range(0, 1) : $urandom_range(0, w);
		repeat (nd) send(flush_req());
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (tensor_queue.size() == 0) begin
				$error("tensor result with nothing expected");
				err_cnt++;
			end else begin
				want = tensor_queue.pop_front();
				if (tensor_e !== want.t.e) begin
					$error("tensor_e expected %h actual %h", want.t.e, tensor_e);
					err_cnt++;
				end
				if (tensor_g !== want.t.g) begin
					$error("tensor_g expected %h actual %h", want.t.g, tensor_g);
					err_cnt++;
				end
				if (tensor_f !== want.t.f) begin
					$error("tensor_f expected %h actual %h", want.t.f, tensor_f);
					err_cnt++;
				end
				if (tensor_mag !== want.t.mag) begin
					$error("tensor_mag expected %h actual %h", want.t.mag, tensor_mag);
					err_cnt++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last expected %b actual %b", want.last, frame_last);
					err_cnt++;
				end
			end
		end
	end

	// result-side stalls
	always @(posedge clk) begin
		pop <= calm || ($urandom_range(99) >= 12);
	end

	initial begin
		dir_row_t dir_tab[$];
		dir_row_t row;
		pix_req_t zp, mx;
		int lim;

		err_cnt = 0;
		sent = 0;
		calm = 0;
		arst_n = 1'b0;
		wr_en = 1'b0; wr_index = REG_WIDTH; wr_data = '0;
		push = 1'b0; func = FN_PIXEL;
		chan_a = '0; chan_b = '0; chan_c = '0;
		held_e = '0; held_g = '0; held_f = '0; held_mag = '0;
		sh_width = RST_WIDTH; sh_height = RST_HEIGHT; sh_thresh = '0; sh_held_en = 1'b0;
		win_cur = '0; win_prev = '0;
		col_cnt = 0; row_cnt = 0; drain_cnt = 0; held_ptr = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 2x2 frames of flat zero, extremes, and flat full scale
		set_config(11'd2, 11'd2, '0, 1'b0);
		zp = '{FN_PIXEL, 0, 0, 0, 0, 0, 0, 0};
		mx = '{FN_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			33'h1_0000_0000, THRESH_TOP};
		for (int i = 0; i < 4; i++) dir_tab.push_back('{zp, i == 3, '0});
		for (int i = 0; i < 3; i++) begin
			row = '{zp, 1, '0};
			row.rq.func = FN_FLUSH;
			row.want.last = (i == 2);
			dir_tab.push_back(row);
		end
		row = '{zp, 0, '0}; row.rq.func = FN_FLUSH; dir_tab.push_back(row);
		row = '{mx, 0, '0}; row.rq.b = 16'h0; dir_tab.push_back(row);
		row = '{mx, 0, '0}; row.rq.func = FN_FLUSH; dir_tab.push_back(row);
		row = '{zp, 0, '0}; row.rq.b = 16'hFFFF; row.rq.hf = 33'h0_FFFF_FFFF;
		dir_tab.push_back(row);
		dir_tab.push_back('{zp, 0, '0});
		dir_tab.push_back('{mx, 0, '0});
		for (int i = 0; i < 3; i++) begin
			row = '{mx, 0, '0}; row.rq.func = FN_FLUSH; dir_tab.push_back(row);
		end
		for (int i = 0; i < 4; i++) dir_tab.push_back('{mx, i == 3, '0});
		for (int i = 0; i < 3; i++) begin
			row = '{mx, 1, '0};
			row.rq.func = FN_FLUSH;
			row.want.last = (i == 2);
			dir_tab.push_back(row);
		end
		foreach (dir_tab[i]) send(dir_tab[i].rq, dir_tab[i].known, dir_tab[i].want);

		// random phases: small frames mostly, a few at the register extremes
		for (int ph = 0; sent < TARGET_ITEMS || ph < 8; ph++) begin
			logic [10:0] w, h;
			logic [33:0] th;
			case (ph)
				0: begin w = 11'd0; h = 11'd0; th = THRESH_TOP; end
				1: begin w = 11'h7FF; h = 11'd2; th = '0; end
				2: begin w = 11'd3; h = 11'h7FF; th = 34'h3_FFFF_FFFF; end
				default: begin
					w = 11'($urandom_range(2, 9));
					h = 11'($urandom_range(2, 5));
					case ($urandom_range(4))
						0: th = '0;
						1: th = THRESH_TOP;
						2: th = {2'($urandom), 32'($urandom)};
						default: th = 34'($urandom_range(0, 32'h4000_0000));
					endcase
				end
			endcase
			if (ph == 1) begin
				// widest row: one full row and a few pixels of the next, left mid-frame
				set_config(w, h, th, 1'($urandom));
				repeat (LINE_MAX + 6) send(rand_pixel(0, '0));
				continue;
			end
			if (ph == 2) begin
				// tall frame: cut short after a few rows, then fall back
				set_config(w, h, th, 1'($urandom));
				repeat (24) send(rand_pixel(0, '0));
				set_config(w, 11'd2, th, 1'($urandom));
				run_frame(1);
				continue;
			end
			set_config(w, h, th, (ph == 0) ? 1'b1 : 1'($urandom));
			lim = $urandom_range(1, 4);
			for (int fr = 0; fr < lim; fr++) run_frame(fr == lim - 1 || $urandom_range(2) != 0);
		end

		push <= 1'b0;
		lim = 0;
		while (tensor_queue.size() != 0 && lim < 200000) begin
			@(posedge clk);
			lim++;
		end
		repeat (100) @(posedge clk);
		if (tensor_queue.size() != 0) begin
			$error("%0d tensor results never arrived", tensor_queue.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/stst_pkg.sv
rtl/core/stst_ram.sv
rtl/core/stst_fifo.sv
rtl/core/stst_front.sv
rtl/core/stst_back.sv
rtl/core/structure_tensor_sobel_threshold_top.sv
rtl/core/stst_checker.sv
verif/structure_tensor_sobel_threshold_top_tb.sv
